FILE: hdl/mrlps_pkg.sv
// Shared constants and types for the multiplexed RGB LED PWM scanner.
package mrlps_pkg;

    localparam int LED_COUNT_DEF = 14;

    localparam int DUTY_W       = 8;
    localparam int LED_INDEX_W  = 4;
    localparam int STEPS_W      = 5;
    localparam int TICKS_W      = 16;
    localparam int PHASE_W      = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int PRODUCT_W    = DUTY_W + STEPS_W;

    localparam logic [STEPS_W-1:0] STEPS_MAX   = STEPS_W'(16);
    localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(10);
    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(1);

    localparam logic [DUTY_W-1:0] RED_RESET   = DUTY_W'(0);
    localparam logic [DUTY_W-1:0] GREEN_RESET = DUTY_W'(0);
    localparam logic [DUTY_W-1:0] BLUE_RESET  = DUTY_W'(255);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PWM_STEPS  = 1'b0,
        REG_SLOT_TICKS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } duty_t;

endpackage

FILE: hdl/mrlps_if.sv
// Request channel interfaces for the scanner's input and output.
interface mrlps_in_if;
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic [mrlps_pkg::LED_INDEX_W-1:0]   led_index;
    logic [mrlps_pkg::DUTY_W-1:0]        red_duty;
    logic [mrlps_pkg::DUTY_W-1:0]        green_duty;
    logic [mrlps_pkg::DUTY_W-1:0]        blue_duty;

    modport source (output valid, func, led_index, red_duty, green_duty, blue_duty,
                    input ready);
    modport sink (input valid, func, led_index, red_duty, green_duty, blue_duty,
                  output ready);
endinterface

interface mrlps_out_if #(parameter int LED_COUNT = mrlps_pkg::LED_COUNT_DEF);
    logic                 valid;
    logic                 ready;
    logic [LED_COUNT-1:0] led_enables;
    logic                 red_on;
    logic                 green_on;
    logic                 blue_on;
    logic                 frame_done;

    modport source (output valid, led_enables, red_on, green_on, blue_on, frame_done,
                    input ready);
    modport sink (input valid, led_enables, red_on, green_on, blue_on, frame_done,
                  output ready);
endinterface

FILE: hdl/multiplexed_rgb_led_pwm_scanner.sv
// Top level of the multiplexed RGB LED PWM scanner with its duty memory.
//
//  Channel   Dir  Handshake        Contents
//  in_ch     in   valid/ready      func, led_index, red/green/blue duty
//  out_ch    out  valid/ready      led_enables, red/green/blue on, frame_done
//  cfg       in   cfg_we           cfg_index, cfg_data (no read-back)
//
// One request is accepted per cycle unless a stalled output fills the read stage; each result
// passes through the duty memory read at the scan slot and then the output register.
// Reset needs no clearing pass: per-entry valid bits supply the reset duties.
// A stalled output holds its result while one more request waits in the read stage.
module multiplexed_rgb_led_pwm_scanner #(
    parameter int LED_COUNT = mrlps_pkg::LED_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mrlps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrlps_pkg::CFG_DATA_W-1:0]  cfg_data,
    mrlps_in_if.sink                          in_ch,
    mrlps_out_if.source                       out_ch
);
    import mrlps_pkg::*;

    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LED_COUNT - 1);

    logic [STEPS_W-1:0]   pwm_steps_reg;
    logic [TICKS_W-1:0]   slot_ticks_reg;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic [TICKS_W-1:0]   dwell_reg, dwell_next;
    logic                 frame_next;

    duty_t                mem [LED_COUNT];
    logic [LED_COUNT-1:0] written_reg;
    duty_t                rd_data_reg;

    logic                 s1_valid_reg;
    logic [IDX_W-1:0]     s1_slot_reg;
    logic [PHASE_W-1:0]   s1_phase_reg;
    logic                 s1_frame_reg;
    logic                 s1_hit_reg;
    logic                 s1_fwd_reg;
    duty_t                s1_fwd_data_reg;

    logic                 out_valid_reg;
    logic [LED_COUNT-1:0] out_enables_reg;
    logic                 out_red_reg;
    logic                 out_green_reg;
    logic                 out_blue_reg;
    logic                 out_frame_reg;

    logic                 accept;
    logic                 s1_adv;
    logic                 is_write;
    logic                 wr_in_range;
    logic [IDX_W-1:0]     wr_addr;
    duty_t                wr_data;
    duty_t                s1_duty;
    duty_t                reset_duty;
    logic [STEPS_W-1:0]   eff_steps;
    logic [TICKS_W-1:0]   eff_ticks;
    logic [PRODUCT_W-1:0] threshold;
    logic [TICKS_W-1:0]   dwell_inc;
    logic                 dwell_wrap;

    assign s1_adv       = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = !s1_valid_reg || s1_adv;
    assign accept       = in_ch.valid && in_ch.ready;
    assign is_write     = (in_ch.func == FUNC_WRITE);
    assign wr_in_range  = ({1'b0, in_ch.led_index} < (LED_INDEX_W + 1)'(LED_COUNT));
    assign wr_addr      = in_ch.led_index[IDX_W-1:0];
    assign wr_data      = '{red: in_ch.red_duty, green: in_ch.green_duty,
                            blue: in_ch.blue_duty};
    assign reset_duty   = '{red: RED_RESET, green: GREEN_RESET, blue: BLUE_RESET};

    always_comb
    begin
        if (pwm_steps_reg == '0)
        begin
            eff_steps = STEPS_W'(1);
        end
        else if (pwm_steps_reg > STEPS_MAX)
        begin
            eff_steps = STEPS_MAX;
        end
        else
        begin
            eff_steps = pwm_steps_reg;
        end
        eff_ticks = (slot_ticks_reg == '0) ? TICKS_W'(1) : slot_ticks_reg;
    end

    // Scan counters advance on each accepted tick request.
    always_comb
    begin
        dwell_inc  = dwell_reg + TICKS_W'(1);
        dwell_wrap = (dwell_inc >= eff_ticks) || (dwell_inc == '0);
        dwell_next = dwell_reg;
        slot_next  = slot_reg;
        phase_next = phase_reg;
        frame_next = 1'b0;
        if (!is_write)
        begin
            dwell_next = dwell_wrap ? '0 : dwell_inc;
            if (dwell_wrap)
            begin
                if (slot_reg >= LAST_SLOT)
                begin
                    slot_next = '0;
                    if (({1'b0, phase_reg} + STEPS_W'(1)) >= eff_steps)
                    begin
                        phase_next = '0;
                        frame_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = phase_reg + PHASE_W'(1);
                    end
                end
                else
                begin
                    slot_next = slot_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_steps_reg  <= STEPS_RESET;
            slot_ticks_reg <= TICKS_RESET;
            phase_reg      <= '0;
            slot_reg       <= '0;
            dwell_reg      <= '0;
            written_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PWM_STEPS:  pwm_steps_reg  <= cfg_data[STEPS_W-1:0];
                    REG_SLOT_TICKS: slot_ticks_reg <= cfg_data[TICKS_W-1:0];
                    default:        ;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                slot_reg  <= slot_next;
                dwell_reg <= dwell_next;
                if (is_write && wr_in_range)
                begin
                    written_reg[wr_addr] <= 1'b1;
                end
            end
            if (in_ch.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Duty memory: one write port, one registered read port at the scan slot.
    always_ff @(posedge clk)
    begin
        if (accept && is_write && wr_in_range)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg     <= slot_reg;
            s1_phase_reg    <= phase_reg;
            s1_frame_reg    <= frame_next;
            s1_hit_reg      <= written_reg[slot_reg];
            s1_fwd_reg      <= is_write && wr_in_range && (wr_addr == slot_reg);
            s1_fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            s1_duty = s1_fwd_data_reg;
        end
        else if (s1_hit_reg)
        begin
            s1_duty = rd_data_reg;
        end
        else
        begin
            s1_duty = reset_duty;
        end
        threshold = {1'b0, s1_phase_reg, {DUTY_W{1'b0}}} - PRODUCT_W'(s1_phase_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_enables_reg <= LED_COUNT'(1) << s1_slot_reg;
            out_red_reg     <= (PRODUCT_W'(s1_duty.red) * PRODUCT_W'(eff_steps)) > threshold;
            out_green_reg   <= (PRODUCT_W'(s1_duty.green) * PRODUCT_W'(eff_steps)) > threshold;
            out_blue_reg    <= (PRODUCT_W'(s1_duty.blue) * PRODUCT_W'(eff_steps)) > threshold;
            out_frame_reg   <= s1_frame_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.led_enables = out_enables_reg;
    assign out_ch.red_on      = out_red_reg;
    assign out_ch.green_on    = out_green_reg;
    assign out_ch.blue_on     = out_blue_reg;
    assign out_ch.frame_done  = out_frame_reg;

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("Scan slot left the LED range.");

    a_enable_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot(out_enables_reg))
        else $error("LED enables are not one-hot.");

    a_frame_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_frame_reg) |-> out_enables_reg[LED_COUNT-1])
        else $error("Frame end reported outside the last slot.");

    a_write_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_write && wr_in_range && (wr_addr == slot_reg))
        |=> (s1_valid_reg && s1_fwd_reg))
        else $error("Write to the active slot was not forwarded.");

    a_scan_hold_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_write) |=> ($stable(slot_reg) && $stable(phase_reg)
                                  && $stable(dwell_reg)))
        else $error("Scan advanced on a write request.");

endmodule
